// ----- design/grid_cell_candidate_dedup_top_macros.svh -----
// assertion helpers for the top-level rtl file
`ifndef GRID_CELL_CANDIDATE_DEDUP_TOP_MACROS_SVH
`define GRID_CELL_CANDIDATE_DEDUP_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define GCCD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define GCCD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/gccd_pkg.sv -----
package gccd_pkg;

  // fixed field widths
  localparam int FUNC_W     = 2;
  localparam int CELL_W     = 12;
  localparam int ID_W       = 10;
  localparam int STATUS_W   = 2;
  localparam int GRID_W     = 7;
  localparam int SEGCNT_W   = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  // default sizes
  localparam int DEF_MAX_CELLS    = 4096;
  localparam int DEF_MAX_SEGMENTS = 1024;
  localparam int DEF_MAX_PER_CELL = 16;
  localparam int DEF_STAMP_BITS   = 8;

  typedef enum logic [FUNC_W-1:0] {
    FN_APPEND = 2'd0,
    FN_CLEAR  = 2'd1,
    FN_QUERY  = 2'd2,
    FN_ACTIVE = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_WIDTH    = 2'd0,
    REG_GRID_HEIGHT   = 2'd1,
    REG_SEGMENT_COUNT = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LEN,
    S_CHECK,
    S_ENT_WAIT,
    S_ID,
    S_MARK,
    S_FINISH,
    S_RESULT
  } state_t;

endpackage

// ----- design/gccd_ram.sv -----
module gccd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- design/grid_cell_candidate_dedup_top.sv -----
// grid cell candidate collector with stamp-based dedup
// input channel (in_valid/in_ready) carries one item: in_func selects append id
// to a cell list, clear every list, begin a query, or present one active cell.
// result channel (out_valid/out_ready) returns found_id, valid_res, last, status;
// every item ends with exactly one result that has last set.
// cfg_we/cfg_index/cfg_wdata write grid_width, grid_height and segment_count;
// a segment_count write clears all seen marks and sets the stamp to one.
// a clear or begin-query item goes straight to its result; an append reads the list
// length, then checks and writes; an active cell reads the length, checks the cell
// range and, if it is inside the grid, walks its list entry by entry.
// each list entry is one entry-memory read, then for an id inside the limits one
// seen-memory read and for a new id one seen-memory write, done in turn by one sequencer.
// one item is worked on at a time; a new item is taken once the previous one
// has handed its final result to the output register.
// if the receiver stalls, the output register holds its result and the walk
// waits before producing the next one, so nothing is dropped.
// reset clears the config registers, sets the stamp to one and runs a clearing
// pass over the list lengths and seen marks; clear table runs the same pass over
// the lengths, and a stamp wrap or segment_count write runs one over the marks;
// no item is accepted during a pass, config writes are taken as usual.
`include "grid_cell_candidate_dedup_top_macros.svh"

module grid_cell_candidate_dedup_top #(
  parameter int MAX_CELLS    = gccd_pkg::DEF_MAX_CELLS,
  parameter int MAX_SEGMENTS = gccd_pkg::DEF_MAX_SEGMENTS,
  parameter int MAX_PER_CELL = gccd_pkg::DEF_MAX_PER_CELL,
  parameter int STAMP_BITS   = gccd_pkg::DEF_STAMP_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [gccd_pkg::FUNC_W-1:0]     in_func,
  input  logic [gccd_pkg::CELL_W-1:0]     in_cell_index,
  input  logic [gccd_pkg::ID_W-1:0]       in_segment_id,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [gccd_pkg::ID_W-1:0]       out_found_id,
  output logic                            out_valid_res,
  output logic                            out_last,
  output logic [gccd_pkg::STATUS_W-1:0]   out_status,
  // config write port
  input  logic                            cfg_we,
  input  logic [gccd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gccd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  import gccd_pkg::*;

  // address and counter widths
  localparam int CELL_AW   = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int SEG_AW    = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int PC_AW     = (MAX_PER_CELL > 1) ? $clog2(MAX_PER_CELL) : 1;
  localparam int LEN_W     = $clog2(MAX_PER_CELL + 1);
  localparam int ENT_AW    = CELL_AW + PC_AW;
  localparam int ENT_DEPTH = MAX_CELLS * (2 ** PC_AW);
  localparam int CLR_DEPTH = (MAX_CELLS > MAX_SEGMENTS) ? MAX_CELLS : MAX_SEGMENTS;
  localparam int CLR_W     = (CLR_DEPTH > 1) ? $clog2(CLR_DEPTH) : 1;

  // sequencer state
  state_t               state_r, state_nxt;
  func_t                func_r, func_nxt;
  logic [CELL_W-1:0]    cell_r, cell_nxt;
  logic [ID_W-1:0]      sid_r, sid_nxt;
  status_t              status_r, status_nxt;
  logic [LEN_W-1:0]     len_r, len_nxt;
  logic [LEN_W-1:0]     i_r, i_nxt;
  logic [ID_W-1:0]      id_r, id_nxt;
  logic [ID_W-1:0]      pend_id_r, pend_id_nxt;
  logic                 have_pend_r, have_pend_nxt;
  logic [STAMP_BITS-1:0] stamp_r, stamp_nxt;
  logic [STAMP_BITS-1:0] stamp_inc;

  // config registers
  logic [GRID_W-1:0]    gw_r, gh_r;
  logic [SEGCNT_W-1:0]  seg_count_r;
  logic                 cfg_seg_wr;

  // clearing pass
  logic [CLR_W-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic                 clr_marks_r, clr_marks_nxt;
  logic                 clr_len_r, clr_len_nxt;
  logic                 clr_busy;
  logic                 start_marks, start_len;

  // output register
  logic                 out_valid_r;
  logic [ID_W-1:0]      out_found_id_r;
  logic                 out_valid_res_r;
  logic                 out_last_r;
  logic [STATUS_W-1:0]  out_status_r;
  logic                 out_free;
  logic                 push;
  logic [ID_W-1:0]      push_id;
  logic                 push_valid;
  logic                 push_last;
  status_t              push_status;

  // memory ports
  logic                 len_we, len_we_walk;
  logic [CELL_AW-1:0]   len_waddr;
  logic [LEN_W-1:0]     len_wdata, len_rdata;
  logic                 ent_we;
  logic [ENT_AW-1:0]    ent_waddr, ent_raddr;
  logic [ID_W-1:0]      ent_rdata;
  logic                 seen_we, seen_we_walk;
  logic [SEG_AW-1:0]    seen_waddr, seen_raddr;
  logic [STAMP_BITS-1:0] seen_wdata, seen_rdata;

  // range checks
  logic [2*GRID_W-1:0]  grid_total;
  logic                 in_fire;
  logic                 append_oob;
  logic                 cell_oob;
  logic                 len_full;
  logic                 id_bad;

  assign in_fire    = in_valid && in_ready;
  assign clr_busy   = clr_marks_r || clr_len_r;
  assign in_ready   = (state_r == S_IDLE) && !clr_busy;
  assign out_free   = !out_valid_r || out_ready;
  assign cfg_seg_wr = cfg_we && (cfg_index == REG_SEGMENT_COUNT);

  assign grid_total = {{GRID_W{1'b0}}, gw_r} * {{GRID_W{1'b0}}, gh_r};
  assign append_oob = 32'(cell_r) >= 32'(MAX_CELLS);
  assign cell_oob   = ({2'b00, cell_r} >= grid_total) || append_oob;
  assign len_full   = 32'(len_rdata) >= 32'(MAX_PER_CELL);
  // ids past segment_count or the mark memory are skipped
  assign id_bad     = ({1'b0, ent_rdata} >= seg_count_r) ||
                      (32'(ent_rdata) >= 32'(MAX_SEGMENTS));
  assign stamp_inc  = stamp_r + STAMP_BITS'(1);

  // per-cell list length, cleared by a sweep
  gccd_ram #(
    .WIDTH(LEN_W),
    .DEPTH(MAX_CELLS),
    .AW   (CELL_AW)
  ) u_len_ram (
    .clk  (clk),
    .we   (len_we),
    .waddr(len_waddr),
    .wdata(len_wdata),
    .raddr(CELL_AW'(cell_r)),
    .rdata(len_rdata)
  );

  // list entries, one row of 2**PC_AW slots per cell
  gccd_ram #(
    .WIDTH(ID_W),
    .DEPTH(ENT_DEPTH),
    .AW   (ENT_AW)
  ) u_ent_ram (
    .clk  (clk),
    .we   (ent_we),
    .waddr(ent_waddr),
    .wdata(sid_r),
    .raddr(ent_raddr),
    .rdata(ent_rdata)
  );

  // seen marks, one stamp per segment
  gccd_ram #(
    .WIDTH(STAMP_BITS),
    .DEPTH(MAX_SEGMENTS),
    .AW   (SEG_AW)
  ) u_seen_ram (
    .clk  (clk),
    .we   (seen_we),
    .waddr(seen_waddr),
    .wdata(seen_wdata),
    .raddr(seen_raddr),
    .rdata(seen_rdata)
  );

  assign ent_waddr = {CELL_AW'(cell_r), PC_AW'(len_rdata)};
  assign ent_raddr = {CELL_AW'(cell_r), PC_AW'(i_r)};

  // sweep owns the write ports while it runs
  assign len_we     = clr_len_r || len_we_walk;
  assign len_waddr  = clr_len_r ? CELL_AW'(clr_cnt_r) : CELL_AW'(cell_r);
  assign len_wdata  = clr_len_r ? '0 : (len_rdata + LEN_W'(1));

  assign seen_we    = clr_marks_r || seen_we_walk;
  assign seen_waddr = clr_marks_r ? SEG_AW'(clr_cnt_r) : SEG_AW'(id_r);
  assign seen_wdata = clr_marks_r ? '0 : stamp_r;
  // look up the id straight off the entry memory, then hold it
  assign seen_raddr = (state_r == S_ID) ? SEG_AW'(ent_rdata) : SEG_AW'(id_r);

  // sequencer: next state, memory strobes and result push
  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    cell_nxt      = cell_r;
    sid_nxt       = sid_r;
    status_nxt    = status_r;
    len_nxt       = len_r;
    i_nxt         = i_r;
    id_nxt        = id_r;
    pend_id_nxt   = pend_id_r;
    have_pend_nxt = have_pend_r;
    stamp_nxt     = stamp_r;
    start_marks   = 1'b0;
    start_len     = 1'b0;
    len_we_walk   = 1'b0;
    ent_we        = 1'b0;
    seen_we_walk  = 1'b0;
    push          = 1'b0;
    push_id       = '0;
    push_valid    = 1'b0;
    push_last     = 1'b0;
    push_status   = ST_OK;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          func_nxt   = func_t'(in_func);
          cell_nxt   = in_cell_index;
          sid_nxt    = in_segment_id;
          status_nxt = ST_OK;
          unique case (func_t'(in_func)) inside
            FN_APPEND, FN_ACTIVE: begin
              state_nxt = S_LEN;
            end
            FN_CLEAR: begin
              start_len = 1'b1;
              state_nxt = S_RESULT;
            end
            FN_QUERY: begin
              // stamp wrap clears every mark and restarts at one
              if (stamp_inc == '0) begin
                stamp_nxt   = STAMP_BITS'(1);
                start_marks = 1'b1;
              end else begin
                stamp_nxt = stamp_inc;
              end
              state_nxt = S_RESULT;
            end
          endcase
        end
      end

      S_LEN: begin
        state_nxt = S_CHECK;
      end

      S_CHECK: begin
        if (func_r == FN_APPEND) begin
          if (append_oob) begin
            status_nxt = ST_RANGE;
          end else if (len_full) begin
            status_nxt = ST_FULL;
          end else begin
            ent_we      = 1'b1;
            len_we_walk = 1'b1;
          end
          state_nxt = S_RESULT;
        end else if (cell_oob) begin
          status_nxt = ST_RANGE;
          state_nxt  = S_RESULT;
        end else begin
          len_nxt       = len_rdata;
          i_nxt         = '0;
          have_pend_nxt = 1'b0;
          state_nxt     = S_ENT_WAIT;
        end
      end

      S_ENT_WAIT: begin
        if (i_r == len_r) begin
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_ID;
        end
      end

      S_ID: begin
        id_nxt = ent_rdata;
        if (id_bad) begin
          i_nxt     = i_r + LEN_W'(1);
          state_nxt = S_ENT_WAIT;
        end else begin
          state_nxt = S_MARK;
        end
      end

      S_MARK: begin
        if (seen_rdata == stamp_r) begin
          i_nxt     = i_r + LEN_W'(1);
          state_nxt = S_ENT_WAIT;
        end else if (!have_pend_r || out_free) begin
          // a new id is found, so the held one is not the last
          if (have_pend_r) begin
            push       = 1'b1;
            push_id    = pend_id_r;
            push_valid = 1'b1;
          end
          seen_we_walk  = 1'b1;
          pend_id_nxt   = id_r;
          have_pend_nxt = 1'b1;
          i_nxt         = i_r + LEN_W'(1);
          state_nxt     = S_ENT_WAIT;
        end
      end

      S_FINISH: begin
        if (out_free) begin
          push       = 1'b1;
          push_id    = have_pend_r ? pend_id_r : '0;
          push_valid = have_pend_r;
          push_last  = 1'b1;
          state_nxt  = S_IDLE;
        end
      end

      S_RESULT: begin
        if (out_free) begin
          push        = 1'b1;
          push_last   = 1'b1;
          push_status = status_r;
          state_nxt   = S_IDLE;
        end
      end
    endcase

    if (cfg_seg_wr) begin
      stamp_nxt   = STAMP_BITS'(1);
      start_marks = 1'b1;
    end
  end

  // sweep control: a new start restarts the counter for both passes
  always_comb begin
    clr_marks_nxt = start_marks ||
                    (clr_marks_r && (clr_cnt_r != CLR_W'(MAX_SEGMENTS - 1)));
    clr_len_nxt   = start_len ||
                    (clr_len_r && (clr_cnt_r != CLR_W'(MAX_CELLS - 1)));
    if (start_marks || start_len) begin
      clr_cnt_nxt = '0;
    end else if (clr_busy) begin
      clr_cnt_nxt = clr_cnt_r + CLR_W'(1);
    end else begin
      clr_cnt_nxt = clr_cnt_r;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_pend_r <= 1'b0;
      stamp_r     <= STAMP_BITS'(1);
      clr_cnt_r   <= '0;
      clr_marks_r <= 1'b1;
      clr_len_r   <= 1'b1;
      out_valid_r <= 1'b0;
      gw_r        <= '0;
      gh_r        <= '0;
      seg_count_r <= '0;
    end else begin
      have_pend_r <= have_pend_nxt;
      stamp_r     <= stamp_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      clr_marks_r <= clr_marks_nxt;
      clr_len_r   <= clr_len_nxt;
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_GRID_WIDTH:    gw_r        <= cfg_wdata[GRID_W-1:0];
          REG_GRID_HEIGHT:   gh_r        <= cfg_wdata[GRID_W-1:0];
          REG_SEGMENT_COUNT: seg_count_r <= cfg_wdata[SEGCNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    func_r    <= func_nxt;
    cell_r    <= cell_nxt;
    sid_r     <= sid_nxt;
    status_r  <= status_nxt;
    len_r     <= len_nxt;
    i_r       <= i_nxt;
    id_r      <= id_nxt;
    pend_id_r <= pend_id_nxt;
    if (push) begin
      out_found_id_r  <= push_id;
      out_valid_res_r <= push_valid;
      out_last_r      <= push_last;
      out_status_r    <= push_status;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_found_id  = out_found_id_r;
  assign out_valid_res = out_valid_res_r;
  assign out_last      = out_last_r;
  assign out_status    = out_status_r;

  `GCCD_ASSERT_NXT(a_accept_leaves_idle, in_fire, state_r != S_IDLE, "item accepted but sequencer stayed idle")
  `GCCD_ASSERT_IMP(a_walk_in_list, state_r == S_ENT_WAIT, i_r <= len_r, "walk index past list length")
  `GCCD_ASSERT_IMP(a_len_bounded, state_r == S_ENT_WAIT, 32'(len_r) <= 32'(MAX_PER_CELL), "list length above cell capacity")
  `GCCD_ASSERT_IMP(a_no_mark_in_sweep, seen_we_walk, !clr_busy, "mark written during clearing pass")
  `GCCD_ASSERT_IMP(a_stamp_nonzero, 1'b1, stamp_r != '0, "query stamp is zero")

endmodule

// ----- dv/grid_cell_candidate_dedup_checker.sv -----
module grid_cell_candidate_dedup_checker
  import gccd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [FUNC_W-1:0]     in_func,
  input  logic [CELL_W-1:0]     in_cell_index,
  input  logic [ID_W-1:0]       in_segment_id,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [ID_W-1:0]       out_found_id,
  input  logic                  out_valid_res,
  input  logic                  out_last,
  input  logic [STATUS_W-1:0]   out_status,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    outstanding,
  output int                    fail_count
);

  localparam int CELLS    = DEF_MAX_CELLS;
  localparam int SEGS     = DEF_MAX_SEGMENTS;
  localparam int PER_CELL = DEF_MAX_PER_CELL;
  localparam int STAMP_W  = DEF_STAMP_BITS;

  typedef struct packed {
    logic [ID_W-1:0] found_id;
    logic            valid_res;
    logic            last;
    status_t         status;
  } candidate_t;

  candidate_t pending_candidates[$];

  logic [STAMP_W-1:0] seen_stamp [SEGS];
  logic [STAMP_W-1:0] query_stamp;
  int unsigned        list_len [CELLS];
  logic [ID_W-1:0]    list_ids [CELLS*PER_CELL];
  int unsigned        grid_w;
  int unsigned        grid_h;
  int unsigned        seg_limit;
  int                 errors = 0;

  function automatic void push_candidate(logic [ID_W-1:0] id, logic vld, logic lst,
                                         status_t st);
    candidate_t c;
    c.found_id  = id;
    c.valid_res = vld;
    c.last      = lst;
    c.status    = st;
    pending_candidates.insert(pending_candidates.size(), c);
  endfunction

  function automatic void forget_marks();
    foreach (seen_stamp[i]) seen_stamp[i] = '0;
    query_stamp = STAMP_W'(1);
  endfunction

  // expected results of one accepted item, state updated on the way
  function automatic void collect_candidates(func_t f, int unsigned cidx,
                                             logic [ID_W-1:0] sid);
    int              found;
    logic [ID_W-1:0] id;
    candidate_t      tail;
    found = 0;
    case (f)
      FN_APPEND: begin
        if (cidx >= CELLS) begin
          push_candidate('0, 1'b0, 1'b1, ST_RANGE);
        end else if (list_len[cidx] >= PER_CELL) begin
          push_candidate('0, 1'b0, 1'b1, ST_FULL);
        end else begin
          list_ids[cidx*PER_CELL + list_len[cidx]] = sid;
          list_len[cidx]++;
          push_candidate('0, 1'b0, 1'b1, ST_OK);
        end
      end
      FN_CLEAR: begin
        foreach (list_len[i]) list_len[i] = 0;
        push_candidate('0, 1'b0, 1'b1, ST_OK);
      end
      FN_QUERY: begin
        query_stamp = query_stamp + 1'b1;
        if (query_stamp == '0) forget_marks();
        push_candidate('0, 1'b0, 1'b1, ST_OK);
      end
      FN_ACTIVE: begin
        if (cidx >= grid_w * grid_h || cidx >= CELLS) begin
          push_candidate('0, 1'b0, 1'b1, ST_RANGE);
        end else begin
          for (int i = 0; i < list_len[cidx] && i < PER_CELL; i++) begin
            id = list_ids[cidx*PER_CELL + i];
            if (id >= seg_limit || id >= SEGS) continue;
            if (seen_stamp[id] == query_stamp) continue;
            seen_stamp[id] = query_stamp;
            push_candidate(id, 1'b1, 1'b0, ST_OK);
            found++;
          end
          if (found == 0) begin
            push_candidate('0, 1'b0, 1'b1, ST_OK);
          end else begin
            tail = pending_candidates.pop_back();
            tail.last = 1'b1;
            pending_candidates.insert(pending_candidates.size(), tail);
          end
        end
      end
    endcase
  endfunction

  function automatic void compare_result();
    candidate_t want;
    if (pending_candidates.size() == 0) begin
      $error("unexpected result: found_id %0d valid_res %0d last %0d status %0d",
             out_found_id, out_valid_res, out_last, out_status);
      errors++;
      return;
    end
    want = pending_candidates.pop_front();
    if (out_found_id !== want.found_id) begin
      $error("found_id: expected %0d, got %0d", want.found_id, out_found_id);
      errors++;
    end
    if (out_valid_res !== want.valid_res) begin
      $error("valid_res: expected %0d, got %0d", want.valid_res, out_valid_res);
      errors++;
    end
    if (out_last !== want.last) begin
      $error("last: expected %0d, got %0d", want.last, out_last);
      errors++;
    end
    if (out_status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, out_status);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      forget_marks();
      foreach (list_len[i]) list_len[i] = 0;
      grid_w    = 0;
      grid_h    = 0;
      seg_limit = 0;
      pending_candidates.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_GRID_WIDTH:    grid_w = 32'(cfg_wdata[GRID_W-1:0]);
          REG_GRID_HEIGHT:   grid_h = 32'(cfg_wdata[GRID_W-1:0]);
          REG_SEGMENT_COUNT: begin
            seg_limit = 32'(cfg_wdata[SEGCNT_W-1:0]);
            forget_marks();
          end
          default: ;
        endcase
      end
      if (out_valid && out_ready) compare_result();
      if (in_valid && in_ready)
        collect_candidates(func_t'(in_func), 32'(in_cell_index), in_segment_id);
    end
    outstanding <= pending_candidates.size();
    fail_count  <= errors;
  end

endmodule

// ----- dv/grid_cell_candidate_dedup_top_tb.sv -----
module grid_cell_candidate_dedup_top_tb;
  import gccd_pkg::*;

  // the one register index the block does not implement, written to show it is ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  // random part size, its calm tail and the length of the long result stall
  localparam int RANDOM_ITEMS = 200;
  localparam int CALM_TAIL    = 30;
  localparam int HOLD_CYCLES  = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // every block input starts at a known value
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [FUNC_W-1:0]     in_func = FN_APPEND;
  logic [CELL_W-1:0]     in_cell_index = '0;
  logic [ID_W-1:0]       in_segment_id = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [ID_W-1:0]       out_found_id;
  logic                  out_valid_res;
  logic                  out_last;
  logic [STATUS_W-1:0]   out_status;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_GRID_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int outstanding;
  int fail_count;

  // shared between the sender and the receiver processes
  bit          steady = 1'b0;         // no idling on either side once set
  bit          long_hold_req = 1'b0;  // receiver takes the long result stall when set
  int          items_sent = 0;

  // configuration as the stimulus knows it, used only to aim cells and ids
  int unsigned cur_w = 0;
  int unsigned cur_h = 0;
  int unsigned cur_segs = 0;
  int unsigned pool_base = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  grid_cell_candidate_dedup_top u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_func       (in_func),
    .in_cell_index (in_cell_index),
    .in_segment_id (in_segment_id),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_found_id  (out_found_id),
    .out_valid_res (out_valid_res),
    .out_last      (out_last),
    .out_status    (out_status),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  grid_cell_candidate_dedup_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_func       (in_func),
    .in_cell_index (in_cell_index),
    .in_segment_id (in_segment_id),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_found_id  (out_found_id),
    .out_valid_res (out_valid_res),
    .out_last      (out_last),
    .out_status    (out_status),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .outstanding   (outstanding),
    .fail_count    (fail_count)
  );

  // offer one item, optionally after an idle burst, and return in the step it is taken
  // valid stays high afterwards so the next call can just swap the payload
  task automatic send_item(func_t f, logic [CELL_W-1:0] cidx, logic [ID_W-1:0] sid);
    if (!steady && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_func       <= f;
    in_cell_index <= cidx;
    in_segment_id <= sid;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // drop valid and wait for every expected result to come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // one register write, with cfg_we dropped again before the task returns
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_GRID_WIDTH:    cur_w = data;
      REG_GRID_HEIGHT:   cur_h = data;
      REG_SEGMENT_COUNT: cur_segs = data;
      default: ;
    endcase
  endtask

  // a cell inside the grid when there is one, else anything
  function automatic logic [CELL_W-1:0] pick_cell();
    if (cur_w * cur_h == 0) return CELL_W'($urandom_range(0, 4095));
    return CELL_W'($urandom_range(0, cur_w * cur_h - 1));
  endfunction

  // ids cluster around the round's pool so several cells share them; a few land anywhere
  function automatic logic [ID_W-1:0] pick_id();
    int unsigned id;
    if ($urandom_range(0, 7) == 0) return ID_W'($urandom_range(0, 1023));
    id = pool_base + $urandom_range(0, 9);
    if (id > 1023) id = 1023;
    return ID_W'(id);
  endfunction

  // grid side: mostly mid sizes, with zero, one and the maximum mixed in
  function automatic int unsigned pick_extent();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return 1;
    if (r <= 3) return 64;
    return $urandom_range(2, 63);
  endfunction

  task automatic random_config();
    int unsigned r;
    if ($urandom_range(0, 1) == 0) write_reg(REG_GRID_WIDTH, pick_extent());
    if ($urandom_range(0, 1) == 0) write_reg(REG_GRID_HEIGHT, pick_extent());
    if ($urandom_range(0, 1) == 0) begin
      r = $urandom_range(0, 9);
      case (r)
        0:       write_reg(REG_SEGMENT_COUNT, 0);
        1:       write_reg(REG_SEGMENT_COUNT, 1);
        2, 3:    write_reg(REG_SEGMENT_COUNT, 1024);
        4:       write_reg(REG_SEGMENT_COUNT, 1023);
        default: write_reg(REG_SEGMENT_COUNT, $urandom_range(1, 1024));
      endcase
    end
  endtask

  // well-formed round: fill a few cells, open a query, then walk its active cells
  // repeats across cells and rounds exercise the dedup; lists build up until full
  task automatic run_round();
    logic [CELL_W-1:0] cells[$];
    int                nc;
    int                na;
    nc = $urandom_range(1, 4);
    pool_base = (cur_segs > 1) ? $urandom_range(0, cur_segs - 1) : 0;
    repeat (nc) cells.insert(cells.size(), pick_cell());
    foreach (cells[i])
      repeat ($urandom_range(0, 4)) send_item(FN_APPEND, cells[i], pick_id());
    // now and then push one list past its capacity
    if ($urandom_range(0, 4) == 0)
      repeat (17) send_item(FN_APPEND, cells[0], pick_id());
    send_item(FN_QUERY, CELL_W'($urandom_range(0, 4095)), ID_W'($urandom_range(0, 1023)));
    na = $urandom_range(1, 6);
    repeat (na) begin
      if ($urandom_range(0, 5) == 0)
        send_item(FN_ACTIVE, CELL_W'($urandom_range(0, 4095)),
                  ID_W'($urandom_range(0, 1023)));
      else
        send_item(FN_ACTIVE, cells[$urandom_range(0, cells.size() - 1)],
                  ID_W'($urandom_range(0, 1023)));
    end
  endtask

  // result side: random ready bursts, one long stall on request, always ready at the end
  initial begin
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold_req = 1'b0;
      end else if (!steady && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  // hard stop well past the slowest legal run, reset clearing pass included
  initial begin
    #10_000_000;
    $display("grid_cell_candidate_dedup_top_tb: FAIL");
    $finish;
  end

  initial begin
    int      goal;
    int      next_cfg;
    int      hold_at;
    bit      hold_done;
    int      pick;
    hold_done = 1'b0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // largest grid and id range; the unused index must change nothing
    write_reg(REG_GRID_WIDTH, 64);
    write_reg(REG_GRID_HEIGHT, 64);
    write_reg(REG_SEGMENT_COUNT, 1024);
    write_reg(REG_SPARE, 32'h7FF);

    // extreme cells and ids, a duplicate inside one list
    send_item(FN_APPEND, 12'd0, 10'd0);
    send_item(FN_APPEND, 12'd4095, 10'd1023);
    send_item(FN_APPEND, 12'd0, 10'd1023);
    send_item(FN_APPEND, 12'd0, 10'd5);
    send_item(FN_APPEND, 12'd0, 10'd0);
    send_item(FN_QUERY, 12'd0, 10'd0);
    send_item(FN_ACTIVE, 12'd0, 10'd0);      // three new ids
    send_item(FN_ACTIVE, 12'd4095, 10'd0);   // its only id already seen this query
    send_item(FN_ACTIVE, 12'd1, 10'd0);      // empty list
    send_item(FN_QUERY, 12'hFFF, 10'h3FF);
    send_item(FN_ACTIVE, 12'd4095, 10'h3FF); // fresh query sees it again
    send_item(FN_ACTIVE, 12'd0, 10'd0);
    send_item(FN_CLEAR, 12'd0, 10'd0);
    send_item(FN_ACTIVE, 12'd0, 10'd0);      // lists are gone
    drain();

    // zero width leaves no valid cell, yet appends still go in
    write_reg(REG_GRID_WIDTH, 0);
    send_item(FN_ACTIVE, 12'd0, 10'd0);
    send_item(FN_APPEND, 12'd4095, 10'h2AA);
    drain();

    // small grid with a tight id limit
    write_reg(REG_GRID_WIDTH, 3);
    write_reg(REG_GRID_HEIGHT, 2);
    write_reg(REG_SEGMENT_COUNT, 4);
    send_item(FN_APPEND, 12'd5, 10'd3);
    send_item(FN_APPEND, 12'd5, 10'd4);      // stored, filtered at query time
    send_item(FN_APPEND, 12'd6, 10'd1);      // append ignores the grid size
    send_item(FN_QUERY, 12'h555, 10'h155);
    send_item(FN_ACTIVE, 12'd5, 10'd0);
    send_item(FN_ACTIVE, 12'd6, 10'd0);      // just past the grid
    send_item(FN_ACTIVE, 12'hAAA, 10'h2AA);
    drain();

    // stamp wrap: fill one list past capacity, report all sixteen, then run the stamp
    // a full lap; marks must be wiped on the wrap so all sixteen come back again
    write_reg(REG_GRID_WIDTH, 64);
    write_reg(REG_GRID_HEIGHT, 64);
    write_reg(REG_SEGMENT_COUNT, 1024);
    send_item(FN_CLEAR, 12'd0, 10'd0);
    for (int i = 0; i < 17; i++) send_item(FN_APPEND, 12'd7, 10'(i * 61));
    send_item(FN_QUERY, 12'd0, 10'd0);
    send_item(FN_ACTIVE, 12'd7, 10'd0);
    repeat (255)
      send_item(FN_QUERY, CELL_W'($urandom_range(0, 4095)), ID_W'($urandom_range(0, 1023)));
    send_item(FN_ACTIVE, 12'd7, 10'd0);
    drain();

    // random part: rounds, table clears and raw noise, with config changes between phases
    goal     = items_sent + RANDOM_ITEMS;
    next_cfg = items_sent + $urandom_range(30, 50);
    hold_at  = items_sent + $urandom_range(40, 80);
    while (items_sent < goal) begin
      if (items_sent >= next_cfg && items_sent < goal - CALM_TAIL) begin
        drain();
        random_config();
        next_cfg = items_sent + $urandom_range(30, 50);
      end
      if (!hold_done && items_sent >= hold_at) begin
        long_hold_req = 1'b1;  // sender keeps offering so the block backs up
        hold_done     = 1'b1;
      end
      if (items_sent >= goal - CALM_TAIL) steady = 1'b1;
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        run_round();
      end else if (pick == 6) begin
        send_item(FN_CLEAR, CELL_W'($urandom_range(0, 4095)), ID_W'($urandom_range(0, 1023)));
      end else begin
        repeat ($urandom_range(1, 4))
          send_item(func_t'($urandom_range(0, 3)), CELL_W'($urandom_range(0, 4095)),
                    ID_W'($urandom_range(0, 1023)));
      end
    end

    // let the last results out, then give stray results time to show up
    drain();
    repeat (64) @(posedge clk);
    if (fail_count == 0) begin
      $display("grid_cell_candidate_dedup_top_tb: PASS");
    end else begin
      $display("grid_cell_candidate_dedup_top_tb: FAIL");
    end
    $finish;
  end

endmodule
